### rtl/core/sdtc_pkg.sv
// shared types for the shift-decode tour cost evaluator
package sdtc_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned CITY_W = 7;
    localparam int unsigned COST_W = 22;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_WR_WEIGHT = 2'd0,
        OP_WR_TOUR   = 2'd1,
        OP_WR_GENE   = 2'd2,
        OP_EVALUATE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_MIGRATE,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIG_PRE,
        ST_MIG,
        ST_SCAT_PRE,
        ST_SCAT,
        ST_COST
    } state_t;

endpackage

### rtl/core/sdtc_ram.sv
// generic single write port ram with registered read
module sdtc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/sdtc_rank_cell.sv
// one rank cell of the migration chain
module sdtc_rank_cell #(
    parameter int unsigned RW  = 6,
    parameter int unsigned IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdtc_pkg::cell_op_t     op,
    input  logic [RW-1:0]          step,
    input  logic [RW-1:0]          old_r,
    input  logic [RW-1:0]          new_r,
    input  logic [RW-1:0]          shift_in,
    output logic [RW-1:0]          rank
);
    import sdtc_pkg::*;

    logic [RW-1:0] rank_reg;
    logic [RW-1:0] rank_next;

    always_comb
    begin
        rank_next = rank_reg;
        case (op)
            CELL_INIT:    rank_next = RW'(IDX);
            CELL_SHIFT:   rank_next = shift_in;
            CELL_MIGRATE:
            begin
                if (step == RW'(IDX))
                begin
                    rank_next = new_r;
                end
                else if (new_r > old_r)
                begin
                    if (rank_reg >= old_r && rank_reg <= new_r)
                    begin
                        rank_next = rank_reg - 1'b1;
                    end
                end
                else if (rank_reg >= new_r && rank_reg < old_r)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            default:      rank_next = rank_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= RW'(IDX);
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    assign rank = rank_reg;
endmodule

### rtl/core/shift_decode_tour_cost_top.sv
// top level: stores, rank cell chain, sequencer and cost accumulator
// an evaluate word runs from accept to the done strobe through these steps for n cities
// (gene prefetch, migration steps, tour prefetch, scatter steps, cost steps, done)
// load words are written on accept and busy stays low; busy stays high while an evaluate runs
// reset clears the sequencer, sets tour_len to 64; stores are not cleared
// done pulses for one cycle with cost; the receiver cannot stall
module shift_decode_tour_cost_top #(
    parameter int unsigned MAX_CITIES  = 64,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [5:0]                   from_city,
    input  logic [5:0]                   to_city,
    input  logic [15:0]                  weight,
    input  logic [5:0]                   position,
    input  logic [6:0]                   city,
    input  logic [5:0]                   shift_gene,
    input  logic                         cfg_we,
    input  logic [6:0]                   cfg_wdata,
    output logic                         done,
    output logic [sdtc_pkg::COST_W-1:0]  cost
);
    import sdtc_pkg::*;

    // widths follow from the city count
    localparam int unsigned RW   = (MAX_CITIES > 2) ? $clog2(MAX_CITIES) : 1;
    localparam int unsigned CW   = $clog2(MAX_CITIES + 3);
    localparam int unsigned WAW  = $clog2(MAX_CITIES * MAX_CITIES);
    localparam int unsigned NCODE = 1 << CITY_W;

    // configuration register
    logic [6:0] tour_len_reg;

    // sequencer
    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   n_clamp;
    logic            accept;
    logic            eval_go;

    // cost pipeline
    logic            s1_v_reg, s1_first_reg, s2_v_reg;
    logic [CITY_W-1:0] prev_reg;
    logic [COST_W-1:0] sum_reg;
    logic [COST_W:0]   sum_wide;
    logic [COST_W-1:0] sum_sat;
    logic [COST_W-1:0] cost_reg;
    logic              done_reg;

    // store ports
    logic [RW-1:0]          gene_raddr, base_raddr, dec_raddr, dec_waddr;
    logic [5:0]             gene_rdata;
    logic [CITY_W-1:0]      base_rdata, dec_rdata;
    logic [WAW-1:0]         w_waddr, w_raddr;
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic                   w_we, tour_we, gene_we, dec_we;

    // chain of rank cells
    logic [RW-1:0]   rank [MAX_CITIES];
    cell_op_t        cell_op;
    logic [RW-1:0]   old_r, new_r;
    logic [RW:0]     r_sum;
    logic [RW-1:0]   g_sat;

    // city number to matrix index, (c - 1) mod MAX_CITIES
    logic [RW-1:0]   cidx_tab [NCODE];
    logic [RW-1:0]   cidx_a, cidx_b;

    for (genvar g = 0; g < NCODE; g++)
    begin : g_cidx
        localparam int unsigned CI = (g + MAX_CITIES - 1) % MAX_CITIES;
        assign cidx_tab[g] = RW'(CI);
    end

    assign accept  = start && !busy;
    assign eval_go = accept && (op_t'(op) == OP_EVALUATE);
    assign busy    = (state_reg != ST_IDLE);

    // tour length clamped to two .. MAX_CITIES
    always_comb
    begin
        if (32'(tour_len_reg) < 32'd2)
        begin
            n_clamp = CW'(2);
        end
        else if (32'(tour_len_reg) > MAX_CITIES)
        begin
            n_clamp = CW'(MAX_CITIES);
        end
        else
        begin
            n_clamp = CW'(tour_len_reg);
        end
    end

    // load words, ignored beyond the store depth
    assign w_we    = accept && (op_t'(op) == OP_WR_WEIGHT) &&
                     (32'(from_city) < MAX_CITIES) && (32'(to_city) < MAX_CITIES);
    assign tour_we = accept && (op_t'(op) == OP_WR_TOUR) && (32'(position) < MAX_CITIES);
    assign gene_we = accept && (op_t'(op) == OP_WR_GENE) && (32'(position) < MAX_CITIES);
    assign w_waddr = WAW'(RW'(from_city)) * WAW'(MAX_CITIES) + WAW'(RW'(to_city));

    // migration: gene of step i was read the cycle before
    assign old_r = rank[cnt_reg[RW-1:0]];
    always_comb
    begin
        if (32'(gene_rdata) >= 32'(n_reg))
        begin
            g_sat = RW'(n_reg - 1'b1);
        end
        else
        begin
            g_sat = RW'(gene_rdata);
        end
        r_sum = {1'b0, old_r} + {1'b0, g_sat};
        if (32'(r_sum) >= 32'(n_reg))
        begin
            new_r = RW'(r_sum - (RW + 1)'(n_reg) + 1'b1);
        end
        else
        begin
            new_r = r_sum[RW-1:0];
        end
    end

    for (genvar j = 0; j < MAX_CITIES; j++)
    begin : g_cell
        logic [RW-1:0] nb;
        if (j == MAX_CITIES - 1)
        begin : g_last
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = rank[j + 1];
        end
        sdtc_rank_cell #(.RW(RW), .IDX(j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (cell_op),
            .step     (cnt_reg[RW-1:0]),
            .old_r    (old_r),
            .new_r    (new_r),
            .shift_in (nb),
            .rank     (rank[j])
        );
    end

    // sequencer: next state, cell control and store addresses
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cell_op    = CELL_HOLD;
        gene_raddr = RW'(cnt_reg);
        base_raddr = RW'(cnt_reg);
        dec_raddr  = RW'(cnt_reg);
        dec_we     = 1'b0;
        dec_waddr  = rank[0];
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_go)
                begin
                    cell_op    = CELL_INIT;
                    state_next = ST_MIG_PRE;
                end
            end
            ST_MIG_PRE:
            begin
                gene_raddr = '0;
                cnt_next   = CW'(1);
                state_next = ST_MIG;
            end
            ST_MIG:
            begin
                cell_op = CELL_MIGRATE;
                if (cnt_reg == n_reg - 1'b1)
                begin
                    state_next = ST_SCAT_PRE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAT_PRE:
            begin
                base_raddr = '0;
                cnt_next   = '0;
                state_next = ST_SCAT;
            end
            ST_SCAT:
            begin
                // element cnt leaves the head of the chain with its rank
                cell_op    = CELL_SHIFT;
                dec_we     = 1'b1;
                base_raddr = RW'(cnt_reg + 1'b1);
                if (cnt_reg == n_reg - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = ST_COST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COST:
            begin
                // last read wraps back to the first city to close the cycle
                if (cnt_reg >= n_reg)
                begin
                    dec_raddr = '0;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == n_reg + CW'(2))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // edge weight lookup between consecutive decoded cities
    assign cidx_a  = cidx_tab[prev_reg];
    assign cidx_b  = cidx_tab[dec_rdata];
    assign w_raddr = WAW'(cidx_a) * WAW'(MAX_CITIES) + WAW'(cidx_b);

    assign sum_wide = {1'b0, sum_reg} + (COST_W + 1)'(w_rdata);
    assign sum_sat  = (sum_wide > {1'b0, COST_MAX}) ? COST_MAX : sum_wide[COST_W-1:0];

    sdtc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_CITIES * MAX_CITIES)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (WEIGHT_BITS'(weight)),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    sdtc_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour_ram (
        .clk   (clk),
        .we    (tour_we),
        .waddr (RW'(position)),
        .wdata (city),
        .raddr (base_raddr),
        .rdata (base_rdata)
    );

    sdtc_ram #(.WIDTH(6), .DEPTH(MAX_CITIES)) u_gene_ram (
        .clk   (clk),
        .we    (gene_we),
        .waddr (RW'(position)),
        .wdata (shift_gene),
        .raddr (gene_raddr),
        .rdata (gene_rdata)
    );

    sdtc_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_decoded_ram (
        .clk   (clk),
        .we    (dec_we),
        .waddr (dec_waddr),
        .wdata (base_rdata),
        .raddr (dec_raddr),
        .rdata (dec_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            tour_len_reg <= 7'd64;
            s1_v_reg     <= 1'b0;
            s1_first_reg <= 1'b0;
            s2_v_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            if (cfg_we)
            begin
                tour_len_reg <= cfg_wdata;
            end
            s1_v_reg     <= (state_reg == ST_COST) && (cnt_reg <= n_reg);
            s1_first_reg <= (cnt_reg == '0);
            s2_v_reg     <= s1_v_reg && !s1_first_reg;
            done_reg     <= (state_reg == ST_COST) && (cnt_reg == n_reg + CW'(2));
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (eval_go)
        begin
            n_reg   <= n_clamp;
            sum_reg <= '0;
        end
        else if (s2_v_reg)
        begin
            sum_reg <= sum_sat;
        end
        if (s1_v_reg)
        begin
            prev_reg <= dec_rdata;
        end
        if ((state_reg == ST_COST) && (cnt_reg == n_reg + CW'(2)))
        begin
            cost_reg <= s2_v_reg ? sum_sat : sum_reg;
        end
    end

    assign done = done_reg;
    assign cost = cost_reg;
endmodule
